[rtl/vrts_pkg.sv]
// Shared widths, codes and item types of the voxel ray traversal stepper.
package vrts_pkg;

    localparam int CELL_IN_W  = 16;
    localparam int PARAM_IN_W = 32;
    localparam int DELTA_W    = 31;
    localparam int DIR_W      = 3;
    localparam int BOUND_W    = 16;
    localparam int BOUNDS_W   = 3 * BOUND_W;
    localparam int OP_W       = 2;
    localparam int AXIS_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int S_TDATA_W  = 176;
    localparam int M_TDATA_W  = 88;
    localparam int ONE_Q16    = 65536;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_FWD  = 2'd1;
    localparam logic [OP_W-1:0] OP_BWD  = 2'd2;

    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH    = 3'd5;

    typedef struct packed {
        logic [PARAM_IN_W-1:0] start_t;
        logic [PARAM_IN_W-1:0] start_tmax_z;
        logic [PARAM_IN_W-1:0] start_tmax_y;
        logic [PARAM_IN_W-1:0] start_tmax_x;
        logic [CELL_IN_W-1:0]  start_cell_z;
        logic [CELL_IN_W-1:0]  start_cell_y;
        logic [CELL_IN_W-1:0]  start_cell_x;
        logic [OP_W-1:0]       operation;
    } t_in_item;

    typedef struct packed {
        logic                  beyond_end;
        logic                  beyond_begin;
        logic                  backward_done;
        logic                  forward_done;
        logic [AXIS_W-1:0]     axis_stepped;
        logic [PARAM_IN_W-1:0] ray_t;
        logic [CELL_IN_W-1:0]  cell_z;
        logic [CELL_IN_W-1:0]  cell_y;
        logic [CELL_IN_W-1:0]  cell_x;
    } t_out_item;

endpackage

[rtl/vrts_axis_pick.sv]
// Chooses the axis with the smallest or largest next crossing, with fixed tie order.
module vrts_axis_pick import vrts_pkg::*; #(
    parameter int PARAM_BITS = 32
) (
    input  logic [PARAM_BITS-1:0] i_cross_x,
    input  logic [PARAM_BITS-1:0] i_cross_y,
    input  logic [PARAM_BITS-1:0] i_cross_z,
    input  logic                  i_forward,
    output logic [AXIS_W-1:0]     o_axis
);

    logic signed [PARAM_BITS-1:0] w_x;
    logic signed [PARAM_BITS-1:0] w_y;
    logic signed [PARAM_BITS-1:0] w_z;

    assign w_x = i_cross_x;
    assign w_y = i_cross_y;
    assign w_z = i_cross_z;

    always_comb begin
        if (i_forward) begin
            if (w_x < w_y && w_x < w_z) begin
                o_axis = AXIS_X;
            end else if (w_y < w_z) begin
                o_axis = AXIS_Y;
            end else begin
                o_axis = AXIS_Z;
            end
        end else begin
            if (w_x > w_y && w_x > w_z) begin
                o_axis = AXIS_X;
            end else if (w_y > w_z) begin
                o_axis = AXIS_Y;
            end else begin
                o_axis = AXIS_Z;
            end
        end
    end

endmodule

[rtl/vrts_axis_move.sv]
// Steps one axis: new cell, bound check and saturating move of its next crossing.
module vrts_axis_move import vrts_pkg::*; #(
    parameter int CELL_BITS  = 16,
    parameter int PARAM_BITS = 32
) (
    input  logic [CELL_BITS-1:0]  i_cell,
    input  logic [PARAM_BITS-1:0] i_cross,
    input  logic [DELTA_W-1:0]    i_span,
    input  logic                  i_neg,
    input  logic                  i_forward,
    input  logic [BOUND_W-1:0]    i_low,
    input  logic [BOUND_W-1:0]    i_high,
    output logic [CELL_BITS-1:0]  o_cell,
    output logic [PARAM_BITS-1:0] o_cross,
    output logic                  o_leave
);

    localparam int XW = (CELL_BITS > BOUND_W) ? CELL_BITS + 1 : BOUND_W + 1;
    localparam int SW = ((PARAM_BITS > DELTA_W + 1) ? PARAM_BITS : DELTA_W + 1) + 1;
    localparam logic [63:0] MAX_U = (64'd1 << (PARAM_BITS - 1)) - 64'd1;
    localparam logic signed [SW-1:0] MAX_P = SW'(MAX_U);
    localparam logic signed [SW-1:0] MIN_P = ~MAX_P;

    logic signed [XW-1:0] w_cell_ext;
    logic signed [XW-1:0] w_fresh;
    logic signed [XW-1:0] w_low_ext;
    logic signed [XW-1:0] w_high_ext;
    logic                 w_dec;
    logic signed [SW-1:0] w_cross_ext;
    logic signed [SW-1:0] w_span_ext;
    logic signed [SW-1:0] w_up;
    logic signed [SW-1:0] w_down;

    assign w_dec      = i_neg ^ ~i_forward;
    assign w_cell_ext = XW'($signed(i_cell));
    assign w_fresh    = w_dec ? (w_cell_ext - XW'(1)) : (w_cell_ext + XW'(1));
    assign w_low_ext  = XW'($signed(i_low));
    assign w_high_ext = XW'($signed(i_high));
    assign o_leave    = (w_fresh < w_low_ext) || (w_fresh > w_high_ext);
    assign o_cell     = w_fresh[CELL_BITS-1:0];

    assign w_cross_ext = SW'($signed(i_cross));
    assign w_span_ext  = SW'(i_span);
    assign w_up        = w_cross_ext + w_span_ext;
    assign w_down      = w_cross_ext - w_span_ext;

    always_comb begin
        if (i_forward) begin
            o_cross = (w_up > MAX_P) ? MAX_P[PARAM_BITS-1:0] : w_up[PARAM_BITS-1:0];
        end else begin
            o_cross = (w_down < MIN_P) ? MIN_P[PARAM_BITS-1:0] : w_down[PARAM_BITS-1:0];
        end
    end

endmodule

[rtl/voxel_ray_traversal_stepper.sv]
// Top level of the voxel ray traversal stepper: registers, handshake and step control.
//
// Requests arrive on the s_axis channel: tuser carries the operation (load, step
// forward, step backward) and tdata the start cell, next crossings and T used by a
// load. Every request yields exactly one result on the m_axis channel with the
// current cell, T, the axis stepped, the sticky done flags and the range flags.
// The configuration port writes the cell spans, step directions and bounds; the user
// must write it only while no request is in flight; the block does not enforce this.
// A request is captured in an input register and is then worked off into the output
// register, from which its result is offered on m_axis.
// One request is taken per cycle unless the receiver stalls; the rate is set by
// the loop of axis choice, cell step and crossing update back into the ray state.
// When the receiver stalls, the result holds in the output register and the input
// register still takes one more request; after that s_axis_tready falls.
// Synchronous reset clears the ray state, the flags, the configuration registers
// and both valid bits.
module voxel_ray_traversal_stepper import vrts_pkg::*; #(
    parameter int CELL_BITS  = 16,
    parameter int PARAM_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // start_cell_x, start_cell_y, start_cell_z, start_tmax_x, start_tmax_y,
    // start_tmax_z, start_t
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // cell_x, cell_y, cell_z, ray_t, forward_done, backward_done, beyond_begin,
    // beyond_end, four zero bits
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // axis_stepped
    output logic [AXIS_W-1:0]     m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TW = (PARAM_BITS > 18) ? PARAM_BITS : 18;

    logic [DELTA_W-1:0]    r_delta_x, r_delta_y, r_delta_z;
    logic [DIR_W-1:0]      r_dirs;
    logic [BOUNDS_W-1:0]   r_low, r_high;

    logic [CELL_BITS-1:0]  r_cell_x, r_cell_y, r_cell_z;
    logic [PARAM_BITS-1:0] r_cross_x, r_cross_y, r_cross_z, r_t;
    logic                  r_fwd_done, r_bwd_done;

    logic [CELL_BITS-1:0]  n_cell_x, n_cell_y, n_cell_z;
    logic [PARAM_BITS-1:0] n_cross_x, n_cross_y, n_cross_z, n_t;
    logic                  n_fwd_done, n_bwd_done;
    logic [AXIS_W-1:0]     n_axis;

    logic                  r_in_valid;
    t_in_item              r_in;
    logic                  r_out_valid;
    t_out_item             r_out;
    t_out_item             n_out;

    logic                  w_adv, w_fire, w_forward, w_leave, w_neg;
    logic [AXIS_W-1:0]     w_axis;
    logic [CELL_BITS-1:0]  w_sel_cell, w_new_cell;
    logic [PARAM_BITS-1:0] w_sel_cross, w_new_cross;
    logic [DELTA_W-1:0]    w_sel_span;
    logic [BOUND_W-1:0]    w_sel_low, w_sel_high;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_forward     = (r_in.operation == OP_FWD);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.axis_stepped;
    assign m_axis_tdata  = {4'b0000, r_out.beyond_end, r_out.beyond_begin,
                            r_out.backward_done, r_out.forward_done, r_out.ray_t,
                            r_out.cell_z, r_out.cell_y, r_out.cell_x};

    vrts_axis_pick #(
        .PARAM_BITS(PARAM_BITS)
    ) u_pick (
        .i_cross_x(r_cross_x),
        .i_cross_y(r_cross_y),
        .i_cross_z(r_cross_z),
        .i_forward(w_forward),
        .o_axis   (w_axis)
    );

    always_comb begin
        case (w_axis)
            AXIS_X: begin
                w_sel_cell  = r_cell_x;
                w_sel_cross = r_cross_x;
                w_sel_span  = r_delta_x;
                w_neg       = r_dirs[0];
                w_sel_low   = r_low[BOUND_W-1:0];
                w_sel_high  = r_high[BOUND_W-1:0];
            end
            AXIS_Y: begin
                w_sel_cell  = r_cell_y;
                w_sel_cross = r_cross_y;
                w_sel_span  = r_delta_y;
                w_neg       = r_dirs[1];
                w_sel_low   = r_low[2*BOUND_W-1:BOUND_W];
                w_sel_high  = r_high[2*BOUND_W-1:BOUND_W];
            end
            default: begin
                w_sel_cell  = r_cell_z;
                w_sel_cross = r_cross_z;
                w_sel_span  = r_delta_z;
                w_neg       = r_dirs[2];
                w_sel_low   = r_low[3*BOUND_W-1:2*BOUND_W];
                w_sel_high  = r_high[3*BOUND_W-1:2*BOUND_W];
            end
        endcase
    end

    vrts_axis_move #(
        .CELL_BITS (CELL_BITS),
        .PARAM_BITS(PARAM_BITS)
    ) u_move (
        .i_cell   (w_sel_cell),
        .i_cross  (w_sel_cross),
        .i_span   (w_sel_span),
        .i_neg    (w_neg),
        .i_forward(w_forward),
        .i_low    (w_sel_low),
        .i_high   (w_sel_high),
        .o_cell   (w_new_cell),
        .o_cross  (w_new_cross),
        .o_leave  (w_leave)
    );

    always_comb begin
        n_cell_x   = r_cell_x;
        n_cell_y   = r_cell_y;
        n_cell_z   = r_cell_z;
        n_cross_x  = r_cross_x;
        n_cross_y  = r_cross_y;
        n_cross_z  = r_cross_z;
        n_t        = r_t;
        n_fwd_done = r_fwd_done;
        n_bwd_done = r_bwd_done;
        n_axis     = AXIS_NONE;
        case (r_in.operation)
            OP_LOAD: begin
                n_cell_x   = CELL_BITS'($signed(r_in.start_cell_x));
                n_cell_y   = CELL_BITS'($signed(r_in.start_cell_y));
                n_cell_z   = CELL_BITS'($signed(r_in.start_cell_z));
                n_cross_x  = PARAM_BITS'($signed(r_in.start_tmax_x));
                n_cross_y  = PARAM_BITS'($signed(r_in.start_tmax_y));
                n_cross_z  = PARAM_BITS'($signed(r_in.start_tmax_z));
                n_t        = PARAM_BITS'($signed(r_in.start_t));
                n_fwd_done = 1'b0;
                n_bwd_done = 1'b0;
            end
            OP_FWD, OP_BWD: begin
                n_t    = w_sel_cross;
                n_axis = w_axis;
                case (w_axis)
                    AXIS_X: begin
                        n_cell_x  = w_new_cell;
                        n_cross_x = w_new_cross;
                    end
                    AXIS_Y: begin
                        n_cell_y  = w_new_cell;
                        n_cross_y = w_new_cross;
                    end
                    default: begin
                        n_cell_z  = w_new_cell;
                        n_cross_z = w_new_cross;
                    end
                endcase
                if (w_leave && w_forward) begin
                    n_fwd_done = 1'b1;
                end
                if (w_leave && !w_forward) begin
                    n_bwd_done = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out.cell_x        = CELL_IN_W'($signed(n_cell_x));
        n_out.cell_y        = CELL_IN_W'($signed(n_cell_y));
        n_out.cell_z        = CELL_IN_W'($signed(n_cell_z));
        n_out.ray_t         = PARAM_IN_W'($signed(n_t));
        n_out.axis_stepped  = n_axis;
        n_out.forward_done  = n_fwd_done;
        n_out.backward_done = n_bwd_done;
        n_out.beyond_begin  = n_t[PARAM_BITS-1];
        n_out.beyond_end    = $signed(TW'($signed(n_t))) > $signed(TW'(ONE_Q16));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta_x <= '0;
            r_delta_y <= '0;
            r_delta_z <= '0;
            r_dirs    <= '0;
            r_low     <= '0;
            r_high    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DELTA_X: r_delta_x <= i_cfg_data[DELTA_W-1:0];
                CFG_DELTA_Y: r_delta_y <= i_cfg_data[DELTA_W-1:0];
                CFG_DELTA_Z: r_delta_z <= i_cfg_data[DELTA_W-1:0];
                CFG_DIRS:    r_dirs    <= i_cfg_data[DIR_W-1:0];
                CFG_LOW:     r_low     <= i_cfg_data[BOUNDS_W-1:0];
                CFG_HIGH:    r_high    <= i_cfg_data[BOUNDS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_x   <= '0;
            r_cell_y   <= '0;
            r_cell_z   <= '0;
            r_cross_x  <= '0;
            r_cross_y  <= '0;
            r_cross_z  <= '0;
            r_t        <= '0;
            r_fwd_done <= 1'b0;
            r_bwd_done <= 1'b0;
        end else if (w_fire) begin
            r_cell_x   <= n_cell_x;
            r_cell_y   <= n_cell_y;
            r_cell_z   <= n_cell_z;
            r_cross_x  <= n_cross_x;
            r_cross_y  <= n_cross_y;
            r_cross_z  <= n_cross_z;
            r_t        <= n_t;
            r_fwd_done <= n_fwd_done;
            r_bwd_done <= n_bwd_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= {s_axis_tdata, s_axis_tuser};
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    a_load_clears_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.operation == OP_LOAD) |=> (!r_fwd_done && !r_bwd_done))
        else $error("done flags not cleared by a load");

    a_step_names_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_in.operation == OP_FWD || r_in.operation == OP_BWD))
        |=> (r_out.axis_stepped != AXIS_NONE))
        else $error("step result without an axis");

    a_fwd_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fwd_done && !(w_fire && r_in.operation == OP_LOAD)) |=> r_fwd_done)
        else $error("forward done flag dropped without a load");

    a_bwd_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bwd_done && !(w_fire && r_in.operation == OP_LOAD)) |=> r_bwd_done)
        else $error("backward done flag dropped without a load");

endmodule

[tb/tb_top.sv]
// Self-checking bench of the voxel ray traversal stepper with a directed table and random rays.
module tb_top;
    import vrts_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE    = 2'd3;
    localparam int              PHASES      = 8;
    localparam int              PHASE_ITEMS = 95;
    localparam int              LONG_HOLD   = 64;
    localparam int              STALL_LIMIT = 1000;
    localparam longint          PARAM_MAX   = 64'sd2147483647;
    localparam longint          PARAM_MIN   = -64'sd2147483648;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // start_cell_x, start_cell_y, start_cell_z, start_tmax_x, start_tmax_y,
    // start_tmax_z, start_t
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    // operation
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // cell_x, cell_y, cell_z, ray_t, forward_done, backward_done, beyond_begin,
    // beyond_end, four zero bits
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    // axis_stepped
    logic [AXIS_W-1:0]     m_axis_tuser;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    voxel_ray_traversal_stepper uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic signed [CELL_IN_W-1:0]  ray_cell  [3];
    logic signed [PARAM_IN_W-1:0] ray_cross [3];
    logic signed [PARAM_IN_W-1:0] ray_param;
    logic                         fwd_left;
    logic                         bwd_left;
    logic [DELTA_W-1:0]           span [3];
    logic [DIR_W-1:0]             dir_bits;
    logic [BOUNDS_W-1:0]          low_b;
    logic [BOUNDS_W-1:0]          high_b;

    t_out_item results_due [$];
    t_in_item  dir_req [$];
    bit        dir_typed [$];
    t_out_item dir_res [$];
    int        mismatches = 0;
    int        quiet = 0;
    bit        calm = 1'b0;
    bit        hold_req = 1'b0;

    initial begin
        for (int a = 0; a < 3; a++) begin
            ray_cell[a]  = '0;
            ray_cross[a] = '0;
            span[a]      = '0;
        end
        ray_param = '0;
        fwd_left  = 1'b0;
        bwd_left  = 1'b0;
        dir_bits  = '0;
        low_b     = '0;
        high_b    = '0;
    end

    function automatic t_in_item mk_req(input logic [OP_W-1:0] op,
                                        input logic [15:0] cx, input logic [15:0] cy,
                                        input logic [15:0] cz, input logic [31:0] tx,
                                        input logic [31:0] ty, input logic [31:0] tz,
                                        input logic [31:0] t);
        return {t, tz, ty, tx, cz, cy, cx, op};
    endfunction

    function automatic t_out_item mk_res(input logic [15:0] cx, input logic [15:0] cy,
                                         input logic [15:0] cz, input logic [31:0] t,
                                         input logic [AXIS_W-1:0] ax, input logic fd,
                                         input logic bd, input logic bb, input logic be);
        return {be, bb, bd, fd, ax, t, cz, cy, cx};
    endfunction

    function automatic logic [15:0] rand_cell();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 24) - 12);
    endfunction

    function automatic logic [31:0] rand_param();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $urandom_range(0, 32'h30000) - 32'h8000;
    endfunction

    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Updates the ray state with one request and gives the result it must produce.
    task automatic advance_ray(input t_in_item r, output t_out_item e);
        int                a;
        bit                fwd;
        bit                left;
        longint            fresh;
        longint            lim_lo;
        longint            lim_hi;
        longint            c;
        longint            d;
        logic [AXIS_W-1:0] ax;
        ax = AXIS_NONE;
        if (r.operation == OP_LOAD) begin
            ray_cell[0]  = r.start_cell_x;
            ray_cell[1]  = r.start_cell_y;
            ray_cell[2]  = r.start_cell_z;
            ray_cross[0] = r.start_tmax_x;
            ray_cross[1] = r.start_tmax_y;
            ray_cross[2] = r.start_tmax_z;
            ray_param    = r.start_t;
            fwd_left     = 1'b0;
            bwd_left     = 1'b0;
        end else if (r.operation == OP_FWD || r.operation == OP_BWD) begin
            fwd = (r.operation == OP_FWD);
            if (fwd)
                a = (ray_cross[0] < ray_cross[1] && ray_cross[0] < ray_cross[2]) ? 0 :
                    (ray_cross[1] < ray_cross[2]) ? 1 : 2;
            else
                a = (ray_cross[0] > ray_cross[1] && ray_cross[0] > ray_cross[2]) ? 0 :
                    (ray_cross[1] > ray_cross[2]) ? 1 : 2;
            fresh  = longint'(ray_cell[a]) + ((dir_bits[a] == fwd) ? -1 : 1);
            lim_lo = longint'($signed(low_b[a*BOUND_W +: BOUND_W]));
            lim_hi = longint'($signed(high_b[a*BOUND_W +: BOUND_W]));
            left   = (fresh < lim_lo) || (fresh > lim_hi);
            ray_param   = ray_cross[a];
            ray_cell[a] = fresh[CELL_IN_W-1:0];
            c = longint'(ray_cross[a]);
            d = longint'(span[a]);
            if (fwd)
                ray_cross[a] = PARAM_IN_W'((c > PARAM_MAX - d) ? PARAM_MAX : c + d);
            else
                ray_cross[a] = PARAM_IN_W'((c < PARAM_MIN + d) ? PARAM_MIN : c - d);
            if (left && fwd)
                fwd_left = 1'b1;
            if (left && !fwd)
                bwd_left = 1'b1;
            ax = (a == 0) ? AXIS_X : (a == 1) ? AXIS_Y : AXIS_Z;
        end
        e = mk_res(ray_cell[0], ray_cell[1], ray_cell[2], ray_param, ax, fwd_left, bwd_left,
                   ray_param < 0, ray_param > ONE_Q16);
    endtask

    task automatic add_checked(input t_in_item r, input t_out_item e);
        dir_req.push_back(r);
        dir_typed.push_back(1'b1);
        dir_res.push_back(e);
    endtask

    task automatic add_predicted(input t_in_item r);
        dir_req.push_back(r);
        dir_typed.push_back(1'b0);
        dir_res.push_back('0);
    endtask

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_req(input t_in_item r, input bit typed, input t_out_item given);
        int        gap;
        t_out_item e;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r[S_TDATA_W+OP_W-1:OP_W];
        s_axis_tuser  <= r.operation;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_ray(r, e);
        results_due.push_back(typed ? given : e);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_DELTA_X: span[0]  = val[DELTA_W-1:0];
            CFG_DELTA_Y: span[1]  = val[DELTA_W-1:0];
            CFG_DELTA_Z: span[2]  = val[DELTA_W-1:0];
            CFG_DIRS:    dir_bits = val[DIR_W-1:0];
            CFG_LOW:     low_b    = val[BOUNDS_W-1:0];
            CFG_HIGH:    high_b   = val[BOUNDS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input t_out_item want, input t_out_item got);
        string want_txt;
        string got_txt;
        mismatches++;
        if (mismatches <= 10) begin
            want_txt = $sformatf("cell %0d,%0d,%0d t %h axis %0d done %b%b range %b%b",
                                 $signed(want.cell_x), $signed(want.cell_y),
                                 $signed(want.cell_z), want.ray_t, want.axis_stepped,
                                 want.forward_done, want.backward_done,
                                 want.beyond_begin, want.beyond_end);
            got_txt  = $sformatf("cell %0d,%0d,%0d t %h axis %0d done %b%b range %b%b",
                                 $signed(got.cell_x), $signed(got.cell_y),
                                 $signed(got.cell_z), got.ray_t, got.axis_stepped,
                                 got.forward_done, got.backward_done,
                                 got.beyond_begin, got.beyond_end);
            $display("%s: expected %s, got %s", what, want_txt, got_txt);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item got;
        t_out_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[83], m_axis_tdata[82], m_axis_tdata[81], m_axis_tdata[80],
                   m_axis_tuser, m_axis_tdata[79:0]};
            if (results_due.size() == 0) begin
                note_mismatch("result with no request pending", '0, got);
            end else begin
                want = results_due.pop_front();
                if (got !== want)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0) begin
                if (hold_req) begin
                    hold_req   = 1'b0;
                    stall_left = LONG_HOLD;
                end else begin
                    stall_left = idle_len();
                end
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [DELTA_W-1:0]  dv [3];
        logic [DIR_W-1:0]    dirs_v;
        logic [BOUNDS_W-1:0] lo_v;
        logic [BOUNDS_W-1:0] hi_v;
        logic [OP_W-1:0]     op;
        int                  sent;
        int                  sel;

        // A spare operation straight after reset must report the cleared state.
        add_checked(mk_req(OP_SPARE, 16'h1234, 16'h5678, 16'h9ABC, 32'h1, 32'h2, 32'h3, 32'h4),
                    mk_res(0, 0, 0, 0, AXIS_NONE, 0, 0, 0, 0));
        add_checked(mk_req(OP_LOAD, 0, 0, 0, 100, 200, 300, 0),
                    mk_res(0, 0, 0, 0, AXIS_NONE, 0, 0, 0, 0));
        add_predicted(mk_req(OP_FWD, '1, '1, '1, '1, '1, '1, '1));
        add_predicted(mk_req(OP_FWD, '1, '1, '1, '1, '1, '1, '1));
        add_predicted(mk_req(OP_BWD, '1, '1, '1, '1, '1, '1, '1));
        // Three-way tie, T just below zero.
        add_checked(mk_req(OP_LOAD, 1, -1, 2, 5, 5, 5, -1),
                    mk_res(1, -1, 2, -1, AXIS_NONE, 0, 0, 1, 0));
        add_predicted(mk_req(OP_FWD, 0, 0, 0, 0, 0, 0, 0));
        add_predicted(mk_req(OP_BWD, 0, 0, 0, 0, 0, 0, 0));
        // Tie of x and y below z, T just past one.
        add_checked(mk_req(OP_LOAD, 0, 0, 0, 7, 7, 9, 65537),
                    mk_res(0, 0, 0, 65537, AXIS_NONE, 0, 0, 0, 1));
        add_predicted(mk_req(OP_FWD, 0, 0, 0, 0, 0, 0, 0));
        add_checked(mk_req(OP_LOAD, 16'h7FFF, 16'h7FFF, 16'h8000, 32'h80000000, 32'h7FFFFFFF,
                           32'h0, 32'h7FFFFFFF),
                    mk_res(16'h7FFF, 16'h7FFF, 16'h8000, 32'h7FFFFFFF, AXIS_NONE, 0, 0, 0, 1));
        add_predicted(mk_req(OP_FWD, 0, 0, 0, 0, 0, 0, 0));
        add_predicted(mk_req(OP_BWD, 0, 0, 0, 0, 0, 0, 0));
        // T exactly one is not beyond the end; the y step then wraps the cell.
        add_checked(mk_req(OP_LOAD, 0, 16'h7FFF, 0, 10, 5, 10, 65536),
                    mk_res(0, 16'h7FFF, 0, 65536, AXIS_NONE, 0, 0, 0, 0));
        add_predicted(mk_req(OP_FWD, 0, 0, 0, 0, 0, 0, 0));
        add_predicted(mk_req(OP_SPARE, '1, '1, '1, '1, '1, '1, '1));
        add_checked(mk_req(OP_LOAD, 16'h8000, 16'h8000, 16'h8000, 0, 0, 32'h80000000,
                           32'h80000000),
                    mk_res(16'h8000, 16'h8000, 16'h8000, 32'h80000000, AXIS_NONE, 0, 0, 1, 0));
        add_predicted(mk_req(OP_BWD, 0, 0, 0, 0, 0, 0, 0));
        add_predicted(mk_req(OP_FWD, 0, 0, 0, 0, 0, 0, 0));
        // Crossings near the bottom of the range saturate on a backward step.
        add_checked(mk_req(OP_LOAD, 0, 0, 0, 32'h80000005, 32'h80000005, 32'h80000005, 0),
                    mk_res(0, 0, 0, 0, AXIS_NONE, 0, 0, 0, 0));
        add_predicted(mk_req(OP_BWD, 0, 0, 0, 0, 0, 0, 0));
        add_predicted(mk_req(OP_FWD, 0, 0, 0, 0, 0, 0, 0));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_reg(CFG_DELTA_X, 48'h7FFFFFFF);
        write_reg(CFG_DELTA_Y, 48'h1);
        write_reg(CFG_DELTA_Z, 48'h10000);
        write_reg(CFG_DIRS, 48'h5);
        write_reg(CFG_LOW, {16'hFFFB, 16'h8000, 16'hFFFE});
        write_reg(CFG_HIGH, {16'h0005, 16'h7FFF, 16'h0002});
        i_cfg_we <= 1'b0;

        for (int k = 0; k < dir_req.size(); k++)
            send_req(dir_req[k], dir_typed[k], dir_res[k]);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    for (int a = 0; a < 3; a++)
                        dv[a] = '0;
                    dirs_v = '0;
                    lo_v   = '0;
                    hi_v   = '0;
                end
                1: begin
                    for (int a = 0; a < 3; a++)
                        dv[a] = '1;
                    dirs_v = '1;
                    lo_v   = {3{16'h8000}};
                    hi_v   = {3{16'h7FFF}};
                end
                default: begin
                    for (int a = 0; a < 3; a++)
                        dv[a] = ($urandom_range(0, 1) != 0) ?
                                DELTA_W'($urandom_range(32'h100, 32'h30000)) : DELTA_W'($urandom);
                    dirs_v = DIR_W'($urandom);
                    if (ph % 2 == 0) begin
                        for (int a = 0; a < 3; a++) begin
                            lo_v[a*BOUND_W +: BOUND_W] = BOUND_W'(-$urandom_range(0, 12));
                            hi_v[a*BOUND_W +: BOUND_W] = BOUND_W'($urandom_range(0, 12));
                        end
                    end else begin
                        lo_v = BOUNDS_W'({$urandom, $urandom});
                        hi_v = BOUNDS_W'({$urandom, $urandom});
                    end
                end
            endcase
            write_reg(CFG_DELTA_X, CFG_DATA_W'(dv[0]));
            write_reg(CFG_DELTA_Y, CFG_DATA_W'(dv[1]));
            write_reg(CFG_DELTA_Z, CFG_DATA_W'(dv[2]));
            write_reg(CFG_DIRS, CFG_DATA_W'(dirs_v));
            write_reg(CFG_LOW, lo_v);
            write_reg(CFG_HIGH, hi_v);
            i_cfg_we <= 1'b0;
            calm     = (ph == 3);
            hold_req = 1'b1;

            // Mostly a fresh ray followed by a run of steps; now and then the run
            // carries on from the previous ray instead.
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 5) != 0) begin
                    send_req(mk_req(OP_LOAD, rand_cell(), rand_cell(), rand_cell(), rand_param(),
                                    rand_param(), rand_param(), rand_param()), 1'b0, '0);
                    sent++;
                end
                repeat ($urandom_range(1, 12)) begin
                    sel = $urandom_range(0, 19);
                    op  = (sel < 12) ? OP_FWD : (sel < 19) ? OP_BWD : OP_SPARE;
                    send_req(mk_req(op, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                                    $urandom, $urandom, $urandom), 1'b0, '0);
                    if (op != OP_SPARE)
                        sent++;
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
